// ===== rtl/core/ncc_pkg.sv =====
// Shared constants, codes and types of the nearest center classifier.
`default_nettype none
package ncc_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIMS_DEF     = 16;
  localparam int COORD_WIDTH_DEF  = 16;

  localparam int CLUSTER_FW = 4;
  localparam int DIM_FW     = 4;
  localparam int DIST_W     = 36;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_METRIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS     = 2'd2;

  localparam logic [1:0] MET_CHEBYSHEV = 2'd0;
  localparam logic [1:0] MET_EUCLIDEAN = 2'd1;
  localparam logic [1:0] MET_CITYBLOCK = 2'd2;

  localparam logic [1:0]            METRIC_RST   = MET_EUCLIDEAN;
  localparam logic [CFG_DATA_W-1:0] CLUSTERS_RST = 5'd2;
  localparam logic [CFG_DATA_W-1:0] DIMS_RST     = 5'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ncc_in_if.sv =====
// Input channel of the classifier: load and sample coordinate transactions.
`default_nettype none
interface ncc_in_if
  import ncc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [CLUSTER_FW-1:0]         cluster;
  logic [DIM_FW-1:0]             dim;
  logic signed [COORD_WIDTH-1:0] coord;
  logic                          last;

  modport source (output valid, op, cluster, dim, coord, last, input ready);
  modport sink   (input valid, op, cluster, dim, coord, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ncc_out_if.sv =====
// Result channel of the classifier: nearest center and its distance.
`default_nettype none
interface ncc_out_if
  import ncc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CLUSTER_FW-1:0] best_cluster;
  logic [DIST_W-1:0]     best_distance;

  modport source (output valid, best_cluster, best_distance, input ready);
  modport sink   (input valid, best_cluster, best_distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ncc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ncc_ram
  import ncc_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/nearest_center_classifier.sv =====
// Top level of the nearest center classifier: sequencer, distance pipeline and result register.
//
// Load transactions write one center coordinate into the center memory.
// For each sample coordinate the sequencer issues the active centers (at most MAX_CLUSTERS),
// one center per cycle, into a four-stage read, difference, square and update pipeline that
// reads, modifies and writes back the running distance memory, and the next transaction is
// taken once the last write-back is done. The final coordinate of a sample also picks the
// nearest center during the same pass, and its result is registered into the output register,
// or held until that register is free. Running distances are cleared by per-center valid flags
// at the first coordinate of each sample, so no clearing pass is needed after reset. Center
// memory contents are undefined until written. New input is accepted while a result waits on the
// output; only a further result stalls the block until the waiting one has been taken.
`default_nettype none
module nearest_center_classifier
  import ncc_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = MAX_DIMS_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  ncc_in_if.sink                     in_ch,
  ncc_out_if.source                  out_ch
);

  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int ADDR_W = $clog2(MAX_CLUSTERS * MAX_DIMS);
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int SAT_W  = (SQ_W > DIST_W) ? SQ_W : DIST_W;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  // Configuration registers.
  logic [1:0]            metric_r;
  logic [CFG_DATA_W-1:0] clusters_r;
  logic [CFG_DATA_W-1:0] dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r   <= METRIC_RST;
      clusters_r <= CLUSTERS_RST;
      dims_r     <= DIMS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METRIC:   metric_r   <= cfg_wdata[1:0];
        CFG_CLUSTERS: clusters_r <= cfg_wdata;
        CFG_DIMS:     dims_r     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  logic [CNT_W-1:0]  ncl;
  logic [DCNT_W-1:0] ndim;

  always_comb begin
    if (clusters_r == '0) begin
      ncl = CNT_W'(1);
    end else if (32'(clusters_r) > MAX_CLUSTERS) begin
      ncl = CNT_W'(MAX_CLUSTERS);
    end else begin
      ncl = CNT_W'(clusters_r);
    end
    if (dims_r == '0) begin
      ndim = DCNT_W'(1);
    end else if (32'(dims_r) > MAX_DIMS) begin
      ndim = DCNT_W'(MAX_DIMS);
    end else begin
      ndim = DCNT_W'(dims_r);
    end
  end

  // Control state.
  state_t                   state_r, state_nxt;
  logic                     sample_open_r, sample_open_nxt;
  logic [MAX_CLUSTERS-1:0]  pd_vld_r, pd_vld_nxt;
  logic [CL_W-1:0]          c_r, c_nxt;
  logic                     issue_done_r, issue_done_nxt;

  // Transaction held for the pass.
  logic signed [COORD_WIDTH-1:0] x_r;
  logic [DIM_FW-1:0]             dim_r;
  logic                          last_r;
  logic                          upd_r;

  // Pipeline registers.
  logic                    s1_vld_r, s2_vld_r, s3_vld_r;
  logic                    s1_lastc_r, s2_lastc_r, s3_lastc_r;
  logic [CL_W-1:0]         s1_c_r, s2_c_r, s3_c_r;
  logic [COORD_WIDTH-1:0]  s2_d_r, s3_d_r;
  logic [DIST_W-1:0]       s2_old_r, s3_old_r;
  logic [SQ_W-1:0]         s3_sq_r;
  logic [DIST_W-1:0]       best_d_r;
  logic [CL_W-1:0]         best_c_r;

  // Output register.
  logic                  out_vld_r, out_vld_nxt;
  logic [CLUSTER_FW-1:0] out_cl_r;
  logic [DIST_W-1:0]     out_dist_r;

  logic in_acc, is_load, is_sample, load_ok;
  logic issue_vld, issue_lastc;
  logic out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_load     = in_acc && (in_ch.op == OP_LOAD);
  assign is_sample   = in_acc && (in_ch.op == OP_SAMPLE);
  assign load_ok     = (32'(in_ch.cluster) < MAX_CLUSTERS) && (32'(in_ch.dim) < MAX_DIMS);
  assign issue_vld   = (state_r == ST_RUN) && !issue_done_r;
  assign issue_lastc = ((CNT_W'(c_r) + CNT_W'(1)) == ncl);
  assign out_free    = !out_vld_r || out_ch.ready;

  // Memories.
  logic [ADDR_W-1:0]      ctr_waddr, ctr_raddr;
  logic [COORD_WIDTH-1:0] ctr_rdata;
  logic                   pd_we;
  logic [DIST_W-1:0]      pd_wdata, pd_rdata;

  assign ctr_waddr = ADDR_W'(32'(in_ch.cluster) * MAX_DIMS + 32'(in_ch.dim));
  assign ctr_raddr = ADDR_W'(32'(c_r) * MAX_DIMS + 32'(dim_r));

  ncc_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (MAX_CLUSTERS * MAX_DIMS)
  ) u_center_ram (
    .clk   (clk),
    .we    (is_load && load_ok),
    .waddr (ctr_waddr),
    .wdata (in_ch.coord),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  ncc_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (pd_we),
    .waddr (s3_c_r),
    .wdata (pd_wdata),
    .raddr (c_r),
    .rdata (pd_rdata)
  );

  // Stage one: center coordinate and running distance arrive from memory.
  logic signed [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH-1:0]      absd;
  logic [DIST_W-1:0]           old_d;

  always_comb begin
    diff = {x_r[COORD_WIDTH-1], x_r} - {ctr_rdata[COORD_WIDTH-1], ctr_rdata};
    absd = diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : diff[COORD_WIDTH-1:0];
    old_d = pd_vld_r[s1_c_r] ? pd_rdata : '0;
  end

  // Stage two: square of the difference.
  logic [SQ_W-1:0] sq;
  assign sq = SQ_W'(s2_d_r) * SQ_W'(s2_d_r);

  // Stage three: update, write back and running minimum.
  logic [SAT_W-1:0]  sq_ext;
  logic [DIST_W-1:0] sq_sat, d_ext, upd_val, new_d, best_d_cur;
  logic [CL_W-1:0]   best_c_cur;
  logic              better;

  always_comb begin
    sq_ext = SAT_W'(s3_sq_r);
    sq_sat = (sq_ext > SAT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq_ext);
    d_ext  = DIST_W'(s3_d_r);
    case (metric_r)
      MET_CHEBYSHEV: upd_val = (d_ext > s3_old_r) ? d_ext : s3_old_r;
      MET_CITYBLOCK: upd_val = sat_add(s3_old_r, d_ext);
      default:       upd_val = sat_add(s3_old_r, sq_sat);
    endcase
    new_d      = upd_r ? upd_val : s3_old_r;
    better     = (s3_c_r == '0) || (new_d < best_d_r);
    best_d_cur = better ? new_d : best_d_r;
    best_c_cur = better ? s3_c_r : best_c_r;
    pd_we      = s3_vld_r;
    pd_wdata   = new_d;
  end

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    sample_open_nxt = sample_open_r;
    pd_vld_nxt      = pd_vld_r;
    c_nxt           = c_r;
    issue_done_nxt  = issue_done_r;
    out_vld_nxt     = out_vld_r && !out_ch.ready;
    if (pd_we) begin
      pd_vld_nxt[s3_c_r] = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (is_sample) begin
          if (!sample_open_r) begin
            pd_vld_nxt = '0;
          end
          sample_open_nxt = 1'b1;
          c_nxt           = '0;
          issue_done_nxt  = 1'b0;
          state_nxt       = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_vld) begin
          if (issue_lastc) begin
            issue_done_nxt = 1'b1;
          end else begin
            c_nxt = c_r + CL_W'(1);
          end
        end
        if (s3_vld_r && s3_lastc_r) begin
          if (last_r) begin
            sample_open_nxt = 1'b0;
            if (out_free) begin
              out_vld_nxt = 1'b1;
              state_nxt   = ST_IDLE;
            end else begin
              state_nxt = ST_HOLD;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      sample_open_r <= 1'b0;
      pd_vld_r      <= '0;
      c_r           <= '0;
      issue_done_r  <= 1'b1;
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
      s3_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sample_open_r <= sample_open_nxt;
      pd_vld_r      <= pd_vld_nxt;
      c_r           <= c_nxt;
      issue_done_r  <= issue_done_nxt;
      s1_vld_r      <= issue_vld;
      s2_vld_r      <= s1_vld_r;
      s3_vld_r      <= s2_vld_r;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      x_r    <= in_ch.coord;
      dim_r  <= in_ch.dim;
      last_r <= in_ch.last;
      upd_r  <= (DCNT_W'(in_ch.dim) < ndim) && (32'(in_ch.dim) < MAX_DIMS);
    end
    s1_c_r     <= c_r;
    s1_lastc_r <= issue_lastc;
    s2_c_r     <= s1_c_r;
    s2_lastc_r <= s1_lastc_r;
    s2_d_r     <= absd;
    s2_old_r   <= old_d;
    s3_c_r     <= s2_c_r;
    s3_lastc_r <= s2_lastc_r;
    s3_d_r     <= s2_d_r;
    s3_old_r   <= s2_old_r;
    s3_sq_r    <= sq;
    if (s3_vld_r) begin
      best_d_r <= best_d_cur;
      best_c_r <= best_c_cur;
    end
    if (s3_vld_r && s3_lastc_r && last_r && out_free) begin
      out_cl_r   <= CLUSTER_FW'(best_c_cur);
      out_dist_r <= best_d_cur;
    end else if (state_r == ST_HOLD && out_free) begin
      out_cl_r   <= CLUSTER_FW'(best_c_r);
      out_dist_r <= best_d_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.best_cluster  = out_cl_r;
  assign out_ch.best_distance = out_dist_r;

  // A write-back only happens inside a pass.
  a_wb_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> state_r == ST_RUN)
    else $error("distance write-back outside a pass");

  // Write-backs never address a center beyond the active count.
  a_wb_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> CNT_W'(s3_c_r) < ncl)
    else $error("distance write-back beyond active centers");

  // A sample transaction always starts a pass.
  a_sample_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.op == OP_SAMPLE) |=> state_r == ST_RUN)
    else $error("sample transaction did not start a pass");

  // A held result only waits while the output register is occupied.
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> out_vld_r)
    else $error("result held while output register is empty");

endmodule
`default_nettype wire
